@@ rtl/sgm_pkg.sv @@
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants of the Sobel gradient magnitude block: payload
// structs, register indexes, dimension limits and the back end state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

    // dimension limits and widths
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT      = 1024;
    localparam int MIN_DIM         = 3;
    localparam int DIM_W           = 11;
    localparam int ROW_W           = 10;
    localparam int COORD_W         = 10;
    localparam int PIX_W           = 8;
    localparam int GRAD_W          = 11;
    localparam int QUEUE_DEPTH_DEF = 4;

    // register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // reset values of the registers
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // input request
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_in_t;

    // result request
    typedef struct packed {
        logic [PIX_W-1:0]   magnitude;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               frame_last;
    } result_t;

    // gradient pair handed from front to back
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [COORD_W-1:0]       out_row;
        logic [COORD_W-1:0]       out_col;
        logic                     frame_last;
    } grad_t;

    // back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_SUM,
        BK_ROOT,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/sgm_queue.sv @@
// ----------------------------------------------------------------------------
// sgm_queue
// Short FIFO of gradient pairs between the window front end and the
// magnitude back end, so that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_queue #(
    parameter int DEPTH = sgm_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire sgm_pkg::grad_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output sgm_pkg::grad_t     pop_data
);
    import sgm_pkg::*;

    grad_t            entry_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    // handshake
    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

@@ rtl/sgm_front.sv @@
// ----------------------------------------------------------------------------
// sgm_front
// Accepts pixels, tracks row and column, keeps the two line stores and the
// 3x3 window, and pushes the Sobel gradient pair of each interior pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_front #(
    parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int DW = (CW + 1 > sgm_pkg::DIM_W) ? CW + 1 : sgm_pkg::DIM_W
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire sgm_pkg::pixel_in_t       in_data,
    input  wire logic [DW-1:0]            width,
    input  wire logic [sgm_pkg::DIM_W-1:0] height,
    output logic                          push_valid,
    input  wire logic                     push_ready,
    output sgm_pkg::grad_t                push_data
);
    import sgm_pkg::*;

    // line stores
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] upper_rd_reg, middle_rd_reg;

    // position counters
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;

    // window columns c-2 and c-1
    logic [PIX_W-1:0] win_reg [6];

    // second stage
    logic               s1_valid_reg;
    logic               s1_emit_reg;
    logic [PIX_W-1:0]   s1_pixel_reg;
    logic [CW-1:0]      s1_idx_reg;
    logic [COORD_W-1:0] s1_row_reg, s1_col_reg;
    logic               s1_last_reg;
    logic               fwd_reg;
    logic [PIX_W-1:0]   fwd_upper_reg, fwd_middle_reg;

    logic               accept, s1_done;
    logic [ROW_W-1:0]   row_a;
    logic [CW-1:0]      col_a, col_m1;
    logic               emit_a, last_a;
    logic [PIX_W-1:0]   t0, m0, b0, t1, m1, b1, t2, m2, b2;
    logic [GRAD_W-1:0]  x_pos, x_neg, y_pos, y_neg;
    logic signed [GRAD_W:0] gx_full, gy_full;

    // handshake: the second stage must drain before a new pixel enters
    assign s1_done  = s1_valid_reg && (!s1_emit_reg || push_ready);
    assign in_stall = s1_valid_reg && s1_emit_reg && !push_ready;
    assign accept   = in_valid && !in_stall;

    // position of the incoming pixel
    assign row_a  = in_data.frame_start ? '0 : row_reg;
    assign col_a  = in_data.frame_start ? '0 : col_reg;
    assign col_m1 = col_a - 1'b1;
    assign emit_a = (row_a >= ROW_W'(2)) && (col_a >= CW'(2))
                 && (DIM_W'(row_a) < height) && (DW'(col_a) < width);
    assign last_a = (DIM_W'(row_a) == height - 1'b1) && (DW'(col_a) == width - 1'b1);

    // counter advance
    always_comb
    begin
        row_next = row_a;
        col_next = col_a + 1'b1;
        if (DW'(col_a) >= width - 1'b1)
        begin
            col_next = '0;
            row_next = (DIM_W'(row_a) >= height - 1'b1) ? '0 : row_a + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // line store read on accept, write when the second stage retires
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_rd_reg  <= upper_mem[col_a];
            middle_rd_reg <= middle_mem[col_a];
        end
        if (s1_done)
        begin
            upper_mem[s1_idx_reg]  <= m2;
            middle_mem[s1_idx_reg] <= s1_pixel_reg;
        end
    end

    // second stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // second stage payload and same-address bypass
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg    <= emit_a;
            s1_pixel_reg   <= in_data.pixel;
            s1_idx_reg     <= col_a;
            s1_row_reg     <= COORD_W'(row_a - 1'b1);
            s1_col_reg     <= COORD_W'(col_m1);
            s1_last_reg    <= last_a;
            fwd_reg        <= s1_valid_reg && (s1_idx_reg == col_a);
            fwd_upper_reg  <= m2;
            fwd_middle_reg <= s1_pixel_reg;
        end
    end

    // window taps
    assign t0 = win_reg[0];
    assign m0 = win_reg[1];
    assign b0 = win_reg[2];
    assign t1 = win_reg[3];
    assign m1 = win_reg[4];
    assign b1 = win_reg[5];
    assign t2 = fwd_reg ? fwd_upper_reg  : upper_rd_reg;
    assign m2 = fwd_reg ? fwd_middle_reg : middle_rd_reg;
    assign b2 = s1_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_done)
        begin
            win_reg[0] <= t1;
            win_reg[1] <= m1;
            win_reg[2] <= b1;
            win_reg[3] <= t2;
            win_reg[4] <= m2;
            win_reg[5] <= b2;
        end
    end

    // sobel gradients
    assign x_pos   = GRAD_W'(t2) + GRAD_W'({m2, 1'b0}) + GRAD_W'(b2);
    assign x_neg   = GRAD_W'(t0) + GRAD_W'({m0, 1'b0}) + GRAD_W'(b0);
    assign y_pos   = GRAD_W'(b0) + GRAD_W'({b1, 1'b0}) + GRAD_W'(b2);
    assign y_neg   = GRAD_W'(t0) + GRAD_W'({t1, 1'b0}) + GRAD_W'(t2);
    assign gx_full = $signed({1'b0, x_pos}) - $signed({1'b0, x_neg});
    assign gy_full = $signed({1'b0, y_pos}) - $signed({1'b0, y_neg});

    // push to the queue
    assign push_valid           = s1_valid_reg && s1_emit_reg;
    assign push_data.gx         = gx_full[GRAD_W-1:0];
    assign push_data.gy         = gy_full[GRAD_W-1:0];
    assign push_data.out_row    = s1_row_reg;
    assign push_data.out_col    = s1_col_reg;
    assign push_data.frame_last = s1_last_reg;

    // checks
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_emit_reg))
        else $error("front stalled without a pending gradient");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.frame_start) |=> (row_reg == '0 && col_reg == CW'(1)))
        else $error("frame start did not restart the counters");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> (DW'(col_reg) < width))
        else $error("column counter beyond width");

endmodule

`default_nettype wire

@@ rtl/sgm_back.sv @@
// ----------------------------------------------------------------------------
// sgm_back
// Turns one gradient pair into a magnitude: squares, sum with saturation,
// then a bit-serial floor square root, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire sgm_pkg::grad_t  pop_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output sgm_pkg::result_t     out_data
);
    import sgm_pkg::*;

    localparam int SQ_W   = 2 * GRAD_W - 2;
    localparam int SUM_W  = SQ_W + 1;
    localparam int REM_W  = 2 * PIX_W;
    localparam int ROOT_W = REM_W + 1;
    localparam int BIT_W  = REM_W - 1;

    back_state_t state_reg, state_next;

    grad_t              item_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic               sat_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;

    logic               out_free, load_out;
    logic signed [2*GRAD_W-1:0] prod_x, prod_y;
    logic [SUM_W-1:0]   sum;
    logic [ROOT_W-1:0]  trial;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (pop_valid) state_next = BK_SQUARE;
            BK_SQUARE: state_next = BK_SUM;
            BK_SUM:    state_next = BK_ROOT;
            BK_ROOT:   if (bit_reg[0]) state_next = BK_OUT;
            BK_OUT:    if (out_free) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pop_ready = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop_ready = 1'b1;
            BK_OUT:  load_out  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // squares, sum and root step
    assign prod_x = item_reg.gx * item_reg.gx;
    assign prod_y = item_reg.gy * item_reg.gy;
    assign sum    = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign trial  = root_reg + ROOT_W'(bit_reg);

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            item_reg <= pop_data;
        end
        if (state_reg == BK_SQUARE)
        begin
            sqx_reg <= prod_x[SQ_W-1:0];
            sqy_reg <= prod_y[SQ_W-1:0];
        end
        if (state_reg == BK_SUM)
        begin
            sat_reg  <= (sum[SUM_W-1:REM_W] != '0);
            rem_reg  <= sum[REM_W-1:0];
            root_reg <= '0;
            bit_reg  <= {1'b1, {(BIT_W-1){1'b0}}};
        end
        if (state_reg == BK_ROOT)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_reg  <= rem_reg - trial[REM_W-1:0];
                root_reg <= (root_reg >> 1) + ROOT_W'(bit_reg);
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.magnitude  <= sat_reg ? {PIX_W{1'b1}} : root_reg[PIX_W-1:0];
            out_data_reg.out_row    <= item_reg.out_row;
            out_data_reg.out_col    <= item_reg.out_col;
            out_data_reg.frame_last <= item_reg.frame_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_sum_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SUM) |=> (state_reg == BK_ROOT))
        else $error("root did not follow sum");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> (state_reg == BK_SQUARE))
        else $error("popped item not taken into square stage");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ rtl/sobel_gradient_magnitude.sv @@
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// 3x3 Sobel edge magnitude over a raster-order 8-bit grayscale stream.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  pixel_in_t  (pixel, frame_start)
//   out      output     out_valid / out_stall result_t   (magnitude, row, col, last)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data (11 bits)
//
// Border pixels are taken one per clock unless the interior pixel before them waits
// on a full queue; the back end handles one interior pixel at a time, through the
// one-bit-per-cycle square root unit. A 4-entry gradient queue lets the front run
// ahead of the root unit. Reset clears counters, window and handshake state; line
// stores are not cleared. cfg_ready is always high; out_stall holds the output
// register and, once the queue fills, stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH   = sgm_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = sgm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire sgm_pkg::pixel_in_t           in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output sgm_pkg::result_t                  out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sgm_pkg::DIM_W-1:0]    cfg_data
);
    import sgm_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DW-1:0]    width_eff;
    logic [DIM_W-1:0] height_eff;

    logic  push_valid, push_ready, pop_valid, pop_ready;
    grad_t push_data, pop_data;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // clamp dimensions to the supported range
    always_comb
    begin
        if (width_reg < DIM_W'(MIN_DIM))
        begin
            width_eff = DW'(MIN_DIM);
        end
        else if (DW'(width_reg) > DW'(MAX_WIDTH))
        begin
            width_eff = DW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = DW'(width_reg);
        end

        if (height_reg < DIM_W'(MIN_DIM))
        begin
            height_eff = DIM_W'(MIN_DIM);
        end
        else if (height_reg > DIM_W'(MAX_HEIGHT))
        begin
            height_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = height_reg;
        end
    end

    // window and gradient front end
    sgm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .width      (width_eff),
        .height     (height_eff),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // gradient queue
    sgm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // magnitude back end
    sgm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
